FILE: hw/rtl/flow_log_table_macros.svh
// assertion helpers used by the top-level rtl file flow_log_table.sv
`ifndef FLOW_LOG_TABLE_MACROS_SVH
`define FLOW_LOG_TABLE_MACROS_SVH

// same-cycle implication, held off while in reset
`define FLT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while in reset
`define FLT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/flt_pkg.sv
`default_nettype none

package flt_pkg;

    typedef enum logic [1:0] {
        KIND_LOG   = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_APPENDED = 3'd1,
        ST_FULL     = 3'd2,
        ST_READ_OK  = 3'd3,
        ST_UNUSED   = 3'd4,
        ST_CLEARED  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_READ,
        BK_RESP
    } bk_state_t;

    // one decoded request as it sits in the queue
    typedef struct packed {
        kind_t              kind;
        logic [31:0]        stamp;
        logic [7:0]         proto;
        logic [7:0]         verdict;
        logic [31:0]        source_addr;
        logic [31:0]        dest_addr;
        logic [15:0]        source_port;
        logic [15:0]        dest_port;
        logic signed [7:0]  why;
        logic [31:0]        first_count;
        logic [7:0]         read_index;
    } cmd_t;

    // one table row as it sits in the ram
    typedef struct packed {
        logic [31:0]        source_addr;
        logic [31:0]        dest_addr;
        logic [15:0]        source_port;
        logic [15:0]        dest_port;
        logic [7:0]         proto;
        logic [31:0]        stamp;
        logic [7:0]         verdict;
        logic signed [7:0]  why;
        logic [31:0]        hit_count;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

FILE: hw/rtl/flt_req_if.sv
`default_nettype none

interface flt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [31:0]        stamp;
    logic [7:0]         proto;
    logic [7:0]         verdict;
    logic [31:0]        source_addr;
    logic [31:0]        dest_addr;
    logic [15:0]        source_port_in;
    logic [15:0]        dest_port_in;
    logic signed [7:0]  why;
    logic [31:0]        first_count;
    logic [7:0]         read_index;

    modport source (
        output valid, kind, stamp, proto, verdict, source_addr, dest_addr,
               source_port_in, dest_port_in, why, first_count, read_index,
        input  ready
    );

    modport sink (
        input  valid, kind, stamp, proto, verdict, source_addr, dest_addr,
               source_port_in, dest_port_in, why, first_count, read_index,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/flt_rsp_if.sv
`default_nettype none

interface flt_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [7:0]         entry_index;
    logic [8:0]         row_total;
    logic [31:0]        out_stamp;
    logic [7:0]         out_proto;
    logic [7:0]         out_verdict;
    logic [31:0]        out_source_addr;
    logic [31:0]        out_dest_addr;
    logic [15:0]        out_source_port;
    logic [15:0]        out_dest_port;
    logic signed [7:0]  out_why;
    logic [31:0]        out_count;

    modport source (
        output valid, status, entry_index, row_total, out_stamp, out_proto,
               out_verdict, out_source_addr, out_dest_addr, out_source_port,
               out_dest_port, out_why, out_count,
        input  ready
    );

    modport sink (
        input  valid, status, entry_index, row_total, out_stamp, out_proto,
               out_verdict, out_source_addr, out_dest_addr, out_source_port,
               out_dest_port, out_why, out_count,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/flow_log_table.sv
// channel   dir   carries
// req       in    kind, stamp, five-tuple, verdict, why, first_count, read_index
// rsp       out   status, entry_index, row_total, contents of the entry read
//
// log request: a scan reads one table row per cycle through the single read port
//   of the table ram, over the used entries up to a hit (none on an empty table)
// read request: one table ram read; unused index and clear request: no ram read
// reset zeroes the row count and the control registers; the table ram needs no clearing pass
// a two-deep request queue keeps req moving while a result waits on rsp
`default_nettype none

`include "flow_log_table_macros.svh"

module flow_log_table
    import flt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic clk,
    input  wire logic rst_n,
    flt_req_if.sink   req,
    flt_rsp_if.source rsp
);

    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] USED_MAX = CW'(TABLE_ENTRIES);

    cmd_t            front_cmd, q_data;
    q_stat_t         q_stat;
    logic            q_push, q_pop;
    logic [CW-1:0]   used;

    flt_front u_front (
        .req    (req),
        .q_stat (q_stat),
        .push   (q_push),
        .cmd    (front_cmd)
    );

    flt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_cmd),
        .pop       (q_pop),
        .pop_data  (q_data),
        .stat      (q_stat)
    );

    flt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_data (q_data),
        .q_stat (q_stat),
        .pop    (q_pop),
        .used   (used),
        .rsp    (rsp)
    );

    `FLT_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, used <= USED_MAX, "row count past table size")
    `FLT_ASSERT_IMP(a_used_step, clk, rst_n, used != $past(used), (used == $past(used) + 1'b1) || (used == '0), "row count moved by other than append or clear")
    `FLT_ASSERT_IMP(a_clear_zero, clk, rst_n, rsp.valid && (rsp.status == ST_CLEARED), (rsp.row_total == '0) && (rsp.entry_index == '0), "clear result with nonzero total or index")
    `FLT_ASSERT_IMP(a_queue_guard, clk, rst_n, q_stat.full, !q_push, "push into full request queue")

endmodule

`default_nettype wire

FILE: hw/rtl/flt_ram.sv
`default_nettype none

module flt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/flt_queue.sv
`default_nettype none

module flt_queue
    import flt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_data,
    input  wire logic pop,
    output cmd_t      pop_data,
    output q_stat_t   stat
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   fill_reg, fill_next;
    logic            do_push, do_pop;

    assign stat.full  = (fill_reg == NW'(QUEUE_DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/flt_front.sv
`default_nettype none

module flt_front
    import flt_pkg::*;
(
    flt_req_if.sink   req,
    input  q_stat_t   q_stat,
    output logic      push,
    output cmd_t      cmd
);

    logic known_kind;

    // kind three is taken and dropped without a result
    always_comb
    begin
        case (req.kind)
            KIND_LOG:   known_kind = 1'b1;
            KIND_READ:  known_kind = 1'b1;
            KIND_CLEAR: known_kind = 1'b1;
            default:    known_kind = 1'b0;
        endcase
    end

    assign req.ready = !q_stat.full;
    assign push      = req.valid && !q_stat.full && known_kind;

    assign cmd.kind        = kind_t'(req.kind);
    assign cmd.stamp       = req.stamp;
    assign cmd.proto       = req.proto;
    assign cmd.verdict     = req.verdict;
    assign cmd.source_addr = req.source_addr;
    assign cmd.dest_addr   = req.dest_addr;
    assign cmd.source_port = req.source_port_in;
    assign cmd.dest_port   = req.dest_port_in;
    assign cmd.why         = req.why;
    assign cmd.first_count = req.first_count;
    assign cmd.read_index  = req.read_index;

endmodule

`default_nettype wire

FILE: hw/rtl/flt_back.sv
`default_nettype none

module flt_back
    import flt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  cmd_t                                    q_data,
    input  q_stat_t                                 q_stat,
    output logic                                    pop,
    output logic [$clog2(TABLE_ENTRIES + 1)-1:0]    used,
    flt_rsp_if.source                               rsp
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int XW = (CW > 9) ? CW : 9;

    bk_state_t       state_reg, state_next;
    cmd_t            cur_reg, cur_next;
    logic [CW-1:0]   used_reg, used_next;
    logic [CW-1:0]   issue_reg, issue_next;
    logic            chk_valid_reg, chk_valid_next;
    logic [IW-1:0]   chk_idx_reg, chk_idx_next;
    status_t         res_status_reg, res_status_next;
    logic [7:0]      res_idx_reg, res_idx_next;
    entry_t          res_entry_reg, res_entry_next;

    logic            rsp_valid_reg, rsp_valid_next;
    status_t         rsp_status_reg, rsp_status_next;
    logic [7:0]      rsp_idx_reg, rsp_idx_next;
    logic [8:0]      rsp_total_reg, rsp_total_next;
    entry_t          rsp_entry_reg, rsp_entry_next;

    logic                      ram_we, ram_re;
    logic [IW-1:0]             ram_waddr, ram_raddr;
    entry_t                    ram_wdata;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t                    rd_entry;

    logic [XW-1:0]   chk_idx_x, used_x, ridx_x;
    logic            key_hit, rsp_free;
    entry_t          new_entry, upd_entry;

    flt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = entry_t'(ram_rdata);
    assign chk_idx_x = XW'(chk_idx_reg);
    assign used_x    = XW'(used_reg);
    assign ridx_x    = XW'(q_data.read_index);
    assign used      = used_reg;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;

    assign key_hit = chk_valid_reg
                  && (rd_entry.source_addr == cur_reg.source_addr)
                  && (rd_entry.dest_addr   == cur_reg.dest_addr)
                  && (rd_entry.source_port == cur_reg.source_port)
                  && (rd_entry.dest_port   == cur_reg.dest_port)
                  && (rd_entry.proto       == cur_reg.proto);

    always_comb
    begin
        new_entry.source_addr = cur_reg.source_addr;
        new_entry.dest_addr   = cur_reg.dest_addr;
        new_entry.source_port = cur_reg.source_port;
        new_entry.dest_port   = cur_reg.dest_port;
        new_entry.proto       = cur_reg.proto;
        new_entry.stamp       = cur_reg.stamp;
        new_entry.verdict     = cur_reg.verdict;
        new_entry.why         = cur_reg.why;
        new_entry.hit_count   = cur_reg.first_count;

        // a hit keeps verdict and reason, refreshes the stamp, bumps the count (saturating at all ones)
        upd_entry           = rd_entry;
        upd_entry.stamp     = cur_reg.stamp;
        upd_entry.hit_count = (rd_entry.hit_count == '1) ? rd_entry.hit_count
                                                         : rd_entry.hit_count + 32'd1;
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        used_next       = used_reg;
        issue_next      = issue_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_entry_next  = res_entry_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_idx_next    = rsp_idx_reg;
        rsp_total_next  = rsp_total_reg;
        rsp_entry_next  = rsp_entry_reg;
        pop             = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = used_reg[IW-1:0];
        ram_wdata       = new_entry;
        ram_re          = 1'b0;
        ram_raddr       = issue_reg[IW-1:0];

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop            = 1'b1;
                    cur_next       = q_data;
                    res_entry_next = '0;
                    case (q_data.kind)
                        KIND_LOG:
                        begin
                            issue_next = '0;
                            state_next = BK_SCAN;
                        end
                        KIND_READ:
                        begin
                            res_idx_next = q_data.read_index;
                            if (ridx_x < used_x)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = ridx_x[IW-1:0];
                                state_next = BK_READ;
                            end
                            else
                            begin
                                res_status_next = ST_UNUSED;
                                state_next      = BK_RESP;
                            end
                        end
                        default:
                        begin
                            used_next       = '0;
                            res_status_next = ST_CLEARED;
                            res_idx_next    = '0;
                            state_next      = BK_RESP;
                        end
                    endcase
                end
            end

            // reads go out one a cycle, each compared when its data returns
            BK_SCAN:
            begin
                if (key_hit)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = chk_idx_reg;
                    ram_wdata       = upd_entry;
                    res_status_next = ST_UPDATED;
                    res_idx_next    = chk_idx_x[7:0];
                    state_next      = BK_RESP;
                end
                else if (issue_reg < used_reg)
                begin
                    ram_re         = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_reg[IW-1:0];
                    issue_next     = issue_reg + 1'b1;
                end
                else if (!chk_valid_reg)
                begin
                    if (used_reg < CW'(TABLE_ENTRIES))
                    begin
                        ram_we          = 1'b1;
                        used_next       = used_reg + 1'b1;
                        res_status_next = ST_APPENDED;
                        res_idx_next    = used_x[7:0];
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                        res_idx_next    = '0;
                    end
                    state_next = BK_RESP;
                end
            end

            BK_READ:
            begin
                res_status_next = ST_READ_OK;
                res_entry_next  = rd_entry;
                state_next      = BK_RESP;
            end

            BK_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_idx_next    = res_idx_reg;
                    rsp_total_next  = used_x[8:0];
                    rsp_entry_next  = res_entry_reg;
                    state_next      = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            used_reg      <= '0;
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        chk_idx_reg    <= chk_idx_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_entry_reg  <= res_entry_next;
        rsp_status_reg <= rsp_status_next;
        rsp_idx_reg    <= rsp_idx_next;
        rsp_total_reg  <= rsp_total_next;
        rsp_entry_reg  <= rsp_entry_next;
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.entry_index     = rsp_idx_reg;
    assign rsp.row_total       = rsp_total_reg;
    assign rsp.out_stamp       = rsp_entry_reg.stamp;
    assign rsp.out_proto       = rsp_entry_reg.proto;
    assign rsp.out_verdict     = rsp_entry_reg.verdict;
    assign rsp.out_source_addr = rsp_entry_reg.source_addr;
    assign rsp.out_dest_addr   = rsp_entry_reg.dest_addr;
    assign rsp.out_source_port = rsp_entry_reg.source_port;
    assign rsp.out_dest_port   = rsp_entry_reg.dest_port;
    assign rsp.out_why         = rsp_entry_reg.why;
    assign rsp.out_count       = rsp_entry_reg.hit_count;

endmodule

`default_nettype wire

FILE: tb/flow_log_table_tb.sv
`timescale 1ns / 1ps

module flow_log_table_tb;
    import flt_pkg::*;

    localparam int          TABLE_DEPTH  = 256;
    localparam int unsigned LIMIT_CYCLES = 1_500_000;
    localparam int          DRAIN_CYCLES = 300;
    localparam logic [1:0]  KIND_IGNORED = 2'd3;

    typedef struct packed {
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  proto;
    } flow_key_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  entry_index;
        logic [8:0]  row_total;
        entry_t      contents;
    } flow_result_t;

    class flow_table_scoreboard;
        entry_t       rows [TABLE_DEPTH];
        int unsigned  used;
        flow_result_t pending [$];
        int unsigned  errors;
        int unsigned  results_seen;

        function new();
            used         = 0;
            errors       = 0;
            results_seen = 0;
        endfunction

        task report_mismatch(string what);
            $display("[%0t] result %0d: %s", $time, results_seen, what);
            errors++;
        endtask

        // works out the result of one accepted request and updates the table copy
        function void note_request(cmd_t c);
            flow_result_t want;
            int           i;
            bit           hit;

            if (c.kind == KIND_IGNORED)
                return;
            want = '0;
            case (c.kind)
                KIND_LOG:
                begin
                    hit = 1'b0;
                    for (i = 0; i < used; i++)
                    begin
                        if (rows[i].source_addr == c.source_addr &&
                            rows[i].dest_addr == c.dest_addr &&
                            rows[i].source_port == c.source_port &&
                            rows[i].dest_port == c.dest_port &&
                            rows[i].proto == c.proto)
                        begin
                            hit = 1'b1;
                            break;
                        end
                    end
                    if (hit)
                    begin
                        rows[i].stamp = c.stamp;
                        if (rows[i].hit_count != '1)
                            rows[i].hit_count++;
                        want.status      = ST_UPDATED;
                        want.entry_index = 8'(i);
                    end
                    else if (used < TABLE_DEPTH)
                    begin
                        rows[used].source_addr = c.source_addr;
                        rows[used].dest_addr   = c.dest_addr;
                        rows[used].source_port = c.source_port;
                        rows[used].dest_port   = c.dest_port;
                        rows[used].proto       = c.proto;
                        rows[used].stamp       = c.stamp;
                        rows[used].verdict     = c.verdict;
                        rows[used].why         = c.why;
                        rows[used].hit_count   = c.first_count;
                        want.status      = ST_APPENDED;
                        want.entry_index = 8'(used);
                        used++;
                    end
                    else
                    begin
                        want.status = ST_FULL;
                    end
                end
                KIND_READ:
                begin
                    want.entry_index = c.read_index;
                    if (c.read_index < used)
                    begin
                        want.status   = ST_READ_OK;
                        want.contents = rows[c.read_index];
                    end
                    else
                    begin
                        want.status = ST_UNUSED;
                    end
                end
                KIND_CLEAR:
                begin
                    used        = 0;
                    want.status = ST_CLEARED;
                end
                default:
                begin
                    return;
                end
            endcase
            want.row_total = 9'(used);
            pending.push_back(want);
        endfunction

        task compare_field(string what, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0h, expected %0h", what, got, want));
        endtask

        task check_response(flow_result_t got);
            flow_result_t want;

            results_seen++;
            if (pending.size() == 0)
            begin
                report_mismatch("result with no request waiting");
                return;
            end
            want = pending.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("entry_index", got.entry_index, want.entry_index);
            compare_field("row_total", got.row_total, want.row_total);
            compare_field("out_stamp", got.contents.stamp, want.contents.stamp);
            compare_field("out_proto", got.contents.proto, want.contents.proto);
            compare_field("out_verdict", got.contents.verdict, want.contents.verdict);
            compare_field("out_source_addr", got.contents.source_addr,
                          want.contents.source_addr);
            compare_field("out_dest_addr", got.contents.dest_addr, want.contents.dest_addr);
            compare_field("out_source_port", got.contents.source_port,
                          want.contents.source_port);
            compare_field("out_dest_port", got.contents.dest_port, want.contents.dest_port);
            compare_field("out_why", got.contents.why, want.contents.why);
            compare_field("out_count", got.contents.hit_count, want.contents.hit_count);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    flt_req_if req_ch();
    flt_rsp_if rsp_ch();

    flow_log_table #(
        .TABLE_ENTRIES (TABLE_DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    flow_table_scoreboard sb = new();

    flow_key_t   known_flows [$];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned stall_left     = 0;
    int unsigned cycle_count    = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("flow_log_table_tb failed");
            $finish;
        end
    end

    // response side: ready drops in bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(17, 1) - 1;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        flow_result_t seen;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen.status               = status_t'(rsp_ch.status);
            seen.entry_index          = rsp_ch.entry_index;
            seen.row_total            = rsp_ch.row_total;
            seen.contents.stamp       = rsp_ch.out_stamp;
            seen.contents.proto       = rsp_ch.out_proto;
            seen.contents.verdict     = rsp_ch.out_verdict;
            seen.contents.source_addr = rsp_ch.out_source_addr;
            seen.contents.dest_addr   = rsp_ch.out_dest_addr;
            seen.contents.source_port = rsp_ch.out_source_port;
            seen.contents.dest_port   = rsp_ch.out_dest_port;
            seen.contents.why         = rsp_ch.out_why;
            seen.contents.hit_count   = rsp_ch.out_count;
            sb.check_response(seen);
        end
    end

    function automatic cmd_t random_cmd(logic [1:0] kind);
        cmd_t c;
        c.kind        = kind_t'(kind);
        c.stamp       = $urandom;
        c.proto       = 8'($urandom);
        c.verdict     = 8'($urandom);
        c.source_addr = $urandom;
        c.dest_addr   = $urandom;
        c.source_port = 16'($urandom);
        c.dest_port   = 16'($urandom);
        c.why         = 8'($urandom);
        c.first_count = $urandom;
        c.read_index  = 8'($urandom);
        return c;
    endfunction

    function automatic flow_key_t fresh_key();
        flow_key_t k;
        k.source_addr = $urandom;
        k.dest_addr   = $urandom;
        k.source_port = 16'($urandom);
        k.dest_port   = 16'($urandom);
        k.proto       = 8'($urandom);
        return k;
    endfunction

    // same flow with one bit flipped in one key field
    function automatic flow_key_t near_key(flow_key_t k);
        case ($urandom_range(4))
            0: k.source_addr[$urandom_range(31)] ^= 1'b1;
            1: k.dest_addr[$urandom_range(31)]   ^= 1'b1;
            2: k.source_port[$urandom_range(15)] ^= 1'b1;
            3: k.dest_port[$urandom_range(15)]   ^= 1'b1;
            default: k.proto[$urandom_range(7)]  ^= 1'b1;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] random_first_count();
        case ($urandom_range(7))
            0: return 32'hFFFF_FFFF;
            1: return 32'hFFFF_FFFE;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned idle_pct();
        case ($urandom_range(2))
            0: return 0;
            1: return 8;
            default: return 30;
        endcase
    endfunction

    task automatic pause_sender(int unsigned cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
    endtask

    task automatic send_request(cmd_t c);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            pause_sender($urandom_range(17, 1));
        @(negedge clk);
        req_ch.valid          <= 1'b1;
        req_ch.kind           <= c.kind;
        req_ch.stamp          <= c.stamp;
        req_ch.proto          <= c.proto;
        req_ch.verdict        <= c.verdict;
        req_ch.source_addr    <= c.source_addr;
        req_ch.dest_addr      <= c.dest_addr;
        req_ch.source_port_in <= c.source_port;
        req_ch.dest_port_in   <= c.dest_port;
        req_ch.why            <= c.why;
        req_ch.first_count    <= c.first_count;
        req_ch.read_index     <= c.read_index;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(c);
    endtask

    task automatic log_flow(flow_key_t k, logic [31:0] stamp, logic [7:0] verdict,
                            logic signed [7:0] why, logic [31:0] first);
        cmd_t c;
        c             = random_cmd(KIND_LOG);
        c.source_addr = k.source_addr;
        c.dest_addr   = k.dest_addr;
        c.source_port = k.source_port;
        c.dest_port   = k.dest_port;
        c.proto       = k.proto;
        c.stamp       = stamp;
        c.verdict     = verdict;
        c.why         = why;
        c.first_count = first;
        send_request(c);
    endtask

    task automatic log_random(flow_key_t k);
        log_flow(k, $urandom, 8'($urandom), 8'($urandom), random_first_count());
    endtask

    task automatic read_row(logic [7:0] index);
        cmd_t c;
        c            = random_cmd(KIND_READ);
        c.read_index = index;
        send_request(c);
    endtask

    task automatic clear_table();
        send_request(random_cmd(KIND_CLEAR));
        known_flows.delete();
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic read_random_index();
        if ($urandom_range(3) == 0)
            read_row(8'($urandom));
        else
            read_row(8'($urandom_range(sb.used < 255 ? sb.used : 255)));
    endtask

    task automatic log_mixed_flow();
        flow_key_t   k;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45 && known_flows.size() != 0)
        begin
            log_random(known_flows[$urandom_range(known_flows.size() - 1)]);
        end
        else
        begin
            if (pick < 60 && known_flows.size() != 0)
                k = near_key(known_flows[$urandom_range(known_flows.size() - 1)]);
            else
                k = fresh_key();
            log_random(k);
            if (known_flows.size() < TABLE_DEPTH)
                known_flows.push_back(k);
        end
    endtask

    // one random request; counted is low for the ignored kind
    task automatic random_request(output bit counted);
        int unsigned pick;
        pick    = $urandom_range(99);
        counted = 1'b1;
        if (pick < 3)
            clear_table();
        else if (pick < 6)
        begin
            send_request(random_cmd(KIND_IGNORED));
            counted = 1'b0;
        end
        else if (pick < 40)
            read_random_index();
        else
            log_mixed_flow();
    endtask

    task automatic random_phase(int unsigned items, bit with_idling);
        int unsigned n;
        bit          counted;
        n = 0;
        while (n < items)
        begin
            if (with_idling && n % 40 == 0)
            begin
                send_idle_pct  = idle_pct();
                recv_stall_pct = idle_pct();
            end
            random_request(counted);
            if (counted)
                n++;
        end
    endtask

    initial
    begin
        flow_key_t zero_key;
        flow_key_t ones_key;
        flow_key_t probe_key;
        flow_key_t swapped_key;
        flow_key_t k;
        int unsigned pick;

        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.kind           = KIND_LOG;
        req_ch.stamp          = '0;
        req_ch.proto          = '0;
        req_ch.verdict        = '0;
        req_ch.source_addr    = '0;
        req_ch.dest_addr      = '0;
        req_ch.source_port_in = '0;
        req_ch.dest_port_in   = '0;
        req_ch.why            = '0;
        req_ch.first_count    = '0;
        req_ch.read_index     = '0;
        rsp_ch.ready          = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct  = 20;
        recv_stall_pct = 20;

        zero_key  = '0;
        ones_key  = '1;
        probe_key = fresh_key();
        swapped_key             = probe_key;
        swapped_key.source_addr = probe_key.dest_addr;
        swapped_key.dest_addr   = probe_key.source_addr;
        swapped_key.source_port = probe_key.dest_port;
        swapped_key.dest_port   = probe_key.source_port;

        // empty table
        read_row(8'd0);
        clear_table();
        // field extremes
        log_flow(zero_key, 32'h0, 8'h00, -8'sd128, 32'h0);
        log_flow(ones_key, 32'hFFFF_FFFF, 8'hFF, 8'sd127, 32'hFFFF_FFFF);
        // hit on a saturated count; stored verdict and reason must stay
        log_flow(ones_key, 32'h1234_5678, 8'h00, -8'sd1, 32'h0);
        read_row(8'd1);
        // count reaches saturation, then holds
        log_flow(probe_key, $urandom, 8'($urandom), 8'($urandom), 32'hFFFF_FFFE);
        log_flow(probe_key, $urandom, 8'($urandom), 8'($urandom), $urandom);
        log_flow(probe_key, $urandom, 8'($urandom), 8'($urandom), $urandom);
        read_row(8'd2);
        // near flows: one key field changed, then source and dest swapped
        k       = probe_key;
        k.proto = probe_key.proto ^ 8'h01;
        log_random(k);
        k           = probe_key;
        k.dest_port = probe_key.dest_port ^ 16'h8000;
        log_random(k);
        log_random(swapped_key);
        read_row(8'd0);
        read_row(8'd5);
        read_row(8'd6);
        read_row(8'd255);
        send_request(random_cmd(KIND_IGNORED));
        clear_table();
        read_row(8'd0);
        log_random(zero_key);
        read_row(8'd0);

        random_phase(250, 1'b1);

        // let everything drain before sending more
        pause_sender($urandom_range(17, 1));
        wait_drained();

        // fill the table to the top, then overflow it
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        clear_table();
        while (sb.used < TABLE_DEPTH)
        begin
            pick = $urandom_range(99);
            if (pick < 15 && known_flows.size() != 0)
                log_random(known_flows[$urandom_range(known_flows.size() - 1)]);
            else if (pick < 30)
                read_random_index();
            else
            begin
                k = fresh_key();
                log_random(k);
                known_flows.push_back(k);
            end
        end
        read_row(8'd255);
        read_row(8'd0);
        repeat (6)
            log_random(fresh_key());
        repeat (4)
            log_random(known_flows[$urandom_range(known_flows.size() - 1)]);
        log_random(known_flows[known_flows.size() - 1]);
        read_row(8'd255);
        read_row(8'($urandom));
        clear_table();

        random_phase(50, 1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_phase(100, 1'b0);

        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("flow_log_table_tb passed");
        else
            $display("flow_log_table_tb failed");
        $finish;
    end

endmodule
